/* rtl/matrix3_inverse_adjugate_defines.svh */
// Assertion macros for the RTL.
`ifndef MATRIX3_INVERSE_ADJUGATE_DEFINES_SVH
`define MATRIX3_INVERSE_ADJUGATE_DEFINES_SVH

// Same-cycle implication.
`define M3I_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Plain check at every edge.
`define M3I_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

/* rtl/m3i_pkg.sv */
package m3i_pkg;

  localparam int ELEMENT_WIDTH = 16;
  localparam int FRACTION_BITS = 8;
  localparam int INV_WIDTH     = 32;
  localparam int INV_FRAC      = 16;
  localparam int NUM_ELEM      = 9;
  localparam int NUM_PROD      = 18;
  localparam int FRONT_STAGES  = 6;

  // Product operand indexes; cofactor i is product 2i minus product 2i+1.
  localparam int PROD_A [NUM_PROD] = '{4, 7, 7, 1, 1, 4, 6, 3, 0, 6,
                                       3, 0, 3, 6, 6, 0, 0, 3};
  localparam int PROD_B [NUM_PROD] = '{8, 5, 2, 8, 5, 2, 5, 8, 8, 2,
                                       2, 5, 7, 4, 1, 7, 4, 1};

endpackage

/* rtl/matrix3_inverse_adjugate.sv */
// Pipeline: an item transferred in passes through 6 cofactor/determinant stages,
//   33 divider stages and 1 output register before out_valid rises.
// Throughput: one matrix per cycle; busy stays low, so start may be held high.
// The nine quotients run in parallel restoring dividers, one quotient bit a stage.
// Reset clears the valid pipeline only; items in flight are dropped.
`include "matrix3_inverse_adjugate_defines.svh"

module matrix3_inverse_adjugate #(
  parameter int ELEMENT_WIDTH = m3i_pkg::ELEMENT_WIDTH,
  parameter int FRACTION_BITS = m3i_pkg::FRACTION_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [ELEMENT_WIDTH-1:0]       in_r0c0,
  input  logic signed [ELEMENT_WIDTH-1:0]       in_r0c1,
  input  logic signed [ELEMENT_WIDTH-1:0]       in_r0c2,
  input  logic signed [ELEMENT_WIDTH-1:0]       in_r1c0,
  input  logic signed [ELEMENT_WIDTH-1:0]       in_r1c1,
  input  logic signed [ELEMENT_WIDTH-1:0]       in_r1c2,
  input  logic signed [ELEMENT_WIDTH-1:0]       in_r2c0,
  input  logic signed [ELEMENT_WIDTH-1:0]       in_r2c1,
  input  logic signed [ELEMENT_WIDTH-1:0]       in_r2c2,
  output logic                                  out_valid,
  output logic signed [m3i_pkg::INV_WIDTH-1:0]  out_inv_r0c0,
  output logic signed [m3i_pkg::INV_WIDTH-1:0]  out_inv_r0c1,
  output logic signed [m3i_pkg::INV_WIDTH-1:0]  out_inv_r0c2,
  output logic signed [m3i_pkg::INV_WIDTH-1:0]  out_inv_r1c0,
  output logic signed [m3i_pkg::INV_WIDTH-1:0]  out_inv_r1c1,
  output logic signed [m3i_pkg::INV_WIDTH-1:0]  out_inv_r1c2,
  output logic signed [m3i_pkg::INV_WIDTH-1:0]  out_inv_r2c0,
  output logic signed [m3i_pkg::INV_WIDTH-1:0]  out_inv_r2c1,
  output logic signed [m3i_pkg::INV_WIDTH-1:0]  out_inv_r2c2,
  output logic signed [3*ELEMENT_WIDTH:0]       out_determinant,
  output logic                                  out_singular
);

  localparam int QB  = m3i_pkg::INV_WIDTH;
  localparam int NE  = m3i_pkg::NUM_ELEM;
  localparam int DW  = 3*ELEMENT_WIDTH + 1;
  localparam int MW  = DW - 1;
  localparam int PW  = 2*ELEMENT_WIDTH;
  localparam int LAT = m3i_pkg::FRONT_STAGES + QB + 2;

  logic                       in_fire;
  logic signed [ELEMENT_WIDTH-1:0] elem [NE];

  logic                       cof_valid;
  logic signed [DW-1:0]       cof_det;
  logic                       cof_sing;
  logic [MW-1:0]              cof_den;
  logic [PW-1:0]              cof_num [NE];
  logic                       cof_neg [NE];

  logic [QB:0]                dv_r;
  logic signed [DW-1:0]       det_r  [QB+1];
  logic                       sing_r [QB+1];
  logic [MW-1:0]              den_r  [QB];
  logic [MW-1:0]              den_s  [QB+1];
  logic signed [QB-1:0]       lane_res [NE];

  logic                       out_valid_r;
  logic signed [QB-1:0]       inv_r  [NE];
  logic signed [DW-1:0]       out_det_r;
  logic                       out_sing_r;

  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  assign elem[0] = in_r0c0;
  assign elem[1] = in_r0c1;
  assign elem[2] = in_r0c2;
  assign elem[3] = in_r1c0;
  assign elem[4] = in_r1c1;
  assign elem[5] = in_r1c2;
  assign elem[6] = in_r2c0;
  assign elem[7] = in_r2c1;
  assign elem[8] = in_r2c2;

  m3i_cofactor #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_cofactor (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (in_fire),
    .elem_i     (elem),
    .valid_o    (cof_valid),
    .det_o      (cof_det),
    .singular_o (cof_sing),
    .den_o      (cof_den),
    .num_o      (cof_num),
    .neg_o      (cof_neg)
  );

  assign den_s[0] = cof_den;
  for (genvar k = 1; k <= QB; k++) begin : g_den
    assign den_s[k] = den_r[k-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      dv_r        <= {dv_r[QB-1:0], cof_valid};
      out_valid_r <= dv_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    den_r[0]  <= cof_den;
    det_r[0]  <= cof_det;
    sing_r[0] <= cof_sing;
    for (int k = 1; k < QB; k++) begin
      den_r[k] <= den_r[k-1];
    end
    for (int k = 1; k <= QB; k++) begin
      det_r[k]  <= det_r[k-1];
      sing_r[k] <= sing_r[k-1];
    end
    for (int i = 0; i < NE; i++) begin
      inv_r[i] <= sing_r[QB] ? '0 : lane_res[i];
    end
    out_det_r  <= sing_r[QB] ? '0 : det_r[QB];
    out_sing_r <= sing_r[QB];
  end

  for (genvar i = 0; i < NE; i++) begin : g_lane
    m3i_div_lane #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_lane (
      .clk   (clk),
      .num_i (cof_num[i]),
      .neg_i (cof_neg[i]),
      .den_i (den_s),
      .res_o (lane_res[i])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_inv_r0c0    = inv_r[0];
  assign out_inv_r0c1    = inv_r[1];
  assign out_inv_r0c2    = inv_r[2];
  assign out_inv_r1c0    = inv_r[3];
  assign out_inv_r1c1    = inv_r[4];
  assign out_inv_r1c2    = inv_r[5];
  assign out_inv_r2c0    = inv_r[6];
  assign out_inv_r2c1    = inv_r[7];
  assign out_inv_r2c2    = inv_r[8];
  assign out_determinant = out_det_r;
  assign out_singular    = out_sing_r;

  `M3I_ASSERT_NOW(a_sing_zero, out_valid && out_singular,
    out_determinant == '0 && out_inv_r0c0 == '0 && out_inv_r1c1 == '0 && out_inv_r2c2 == '0,
    "singular result carries nonzero data")
  `M3I_ASSERT_NOW(a_det_nonzero, out_valid && !out_singular, out_determinant != '0,
    "nonsingular result with zero determinant")
  `M3I_ASSERT_NOW(a_latency, out_valid, $past(in_fire, LAT),
    "result without matching transfer in")

endmodule

/* rtl/m3i_cofactor.sv */
module m3i_cofactor #(
  parameter int ELEMENT_WIDTH = m3i_pkg::ELEMENT_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              valid_i,
  input  logic signed [ELEMENT_WIDTH-1:0]   elem_i [m3i_pkg::NUM_ELEM],
  output logic                              valid_o,
  output logic signed [3*ELEMENT_WIDTH:0]   det_o,
  output logic                              singular_o,
  output logic        [3*ELEMENT_WIDTH-1:0] den_o,
  output logic        [2*ELEMENT_WIDTH-1:0] num_o [m3i_pkg::NUM_ELEM],
  output logic                              neg_o [m3i_pkg::NUM_ELEM]
);

  localparam int EW = ELEMENT_WIDTH;
  localparam int PW = 2*EW;
  localparam int AW = PW + 1;
  localparam int DW = 3*EW + 1;
  localparam int MW = DW - 1;
  localparam int NE = m3i_pkg::NUM_ELEM;
  localparam int NP = m3i_pkg::NUM_PROD;
  localparam int NS = m3i_pkg::FRONT_STAGES;

  logic [NS-1:0]           v_r;
  logic signed [EW-1:0]    el_r   [NE];
  logic signed [PW-1:0]    p_r    [NP];
  logic signed [EW-1:0]    abc2_r [3];
  logic signed [EW-1:0]    abc3_r [3];
  logic signed [AW-1:0]    adj3_r [NE];
  logic signed [AW-1:0]    adj4_r [NE];
  logic signed [AW-1:0]    adj5_r [NE];
  logic signed [DW-1:0]    t_r    [3];
  logic signed [DW-1:0]    det5_r;
  logic signed [DW-1:0]    det6_r;
  logic                    sing_r;
  logic [MW-1:0]           den_r;
  logic [PW-1:0]           num_r  [NE];
  logic                    neg_r  [NE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NE; i++) begin
      el_r[i] <= elem_i[i];
    end
    for (int j = 0; j < NP; j++) begin
      p_r[j] <= PW'(el_r[m3i_pkg::PROD_A[j]]) * PW'(el_r[m3i_pkg::PROD_B[j]]);
    end
    for (int j = 0; j < 3; j++) begin
      abc2_r[j] <= el_r[j];
      abc3_r[j] <= abc2_r[j];
    end
    for (int i = 0; i < NE; i++) begin
      adj3_r[i] <= AW'(p_r[2*i]) - AW'(p_r[2*i+1]);
      adj4_r[i] <= adj3_r[i];
      adj5_r[i] <= adj4_r[i];
    end
    t_r[0] <= DW'(abc3_r[0]) * DW'(adj3_r[0]);
    t_r[1] <= DW'(abc3_r[1]) * DW'(adj3_r[3]);
    t_r[2] <= DW'(abc3_r[2]) * DW'(adj3_r[6]);
    det5_r <= t_r[0] + t_r[1] + t_r[2];
    det6_r <= det5_r;
    sing_r <= (det5_r == '0);
    den_r  <= det5_r[DW-1] ? MW'(-det5_r) : MW'(det5_r);
    for (int i = 0; i < NE; i++) begin
      num_r[i] <= adj5_r[i][AW-1] ? PW'(-adj5_r[i]) : PW'(adj5_r[i]);
      neg_r[i] <= adj5_r[i][AW-1] ^ det5_r[DW-1];
    end
  end

  assign valid_o    = v_r[NS-1];
  assign det_o      = det6_r;
  assign singular_o = sing_r;
  assign den_o      = den_r;
  assign num_o      = num_r;
  assign neg_o      = neg_r;

endmodule

/* rtl/m3i_div_lane.sv */
module m3i_div_lane #(
  parameter int ELEMENT_WIDTH = m3i_pkg::ELEMENT_WIDTH,
  parameter int FRACTION_BITS = m3i_pkg::FRACTION_BITS
) (
  input  logic                                  clk,
  input  logic        [2*ELEMENT_WIDTH-1:0]     num_i,
  input  logic                                  neg_i,
  input  logic        [3*ELEMENT_WIDTH-1:0]     den_i [m3i_pkg::INV_WIDTH+1],
  output logic signed [m3i_pkg::INV_WIDTH-1:0]  res_o
);

  localparam int QB  = m3i_pkg::INV_WIDTH;
  localparam int NMW = 2*ELEMENT_WIDTH;
  localparam int MW  = 3*ELEMENT_WIDTH;
  localparam int SH  = FRACTION_BITS + m3i_pkg::INV_FRAC;
  localparam int NW  = NMW + SH;
  localparam int CW  = NW + MW;

  logic [MW-1:0] rem_r [QB+1];
  logic [QB-1:0] low_r [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          sat_r [QB+1];
  logic          neg_r [QB+1];

  logic [NW-1:0] n_full;
  logic [NW-1:0] n_hi;

  assign n_full = NW'(num_i) << SH;
  assign n_hi   = n_full >> QB;

  always_ff @(posedge clk) begin
    rem_r[0] <= MW'(n_hi);
    low_r[0] <= n_full[QB-1:0];
    q_r[0]   <= '0;
    sat_r[0] <= CW'(n_hi) >= CW'(den_i[0]);
    neg_r[0] <= neg_i;
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [MW:0] trial;
    logic [MW:0] diff;
    logic        ge;

    assign trial = {rem_r[k-1], low_r[k-1][QB-1]};
    assign diff  = trial - {1'b0, den_i[k]};
    assign ge    = trial >= {1'b0, den_i[k]};

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[MW-1:0] : trial[MW-1:0];
      low_r[k] <= {low_r[k-1][QB-2:0], 1'b0};
      q_r[k]   <= {q_r[k-1][QB-2:0], ge};
      sat_r[k] <= sat_r[k-1];
      neg_r[k] <= neg_r[k-1];
    end
  end

  always_comb begin
    logic [QB-1:0] lim;
    logic [QB-1:0] mag;
    lim = neg_r[QB] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
    mag = (sat_r[QB] || (q_r[QB] > lim)) ? lim : q_r[QB];
    res_o = neg_r[QB] ? signed'(-mag) : signed'(mag);
  end

endmodule

/* tb/matrix3_inverse_adjugate_tb.sv */
module matrix3_inverse_adjugate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EW = m3i_pkg::ELEMENT_WIDTH;
  localparam int IW = m3i_pkg::INV_WIDTH;
  localparam int DW = 3 * EW + 1;
  localparam int INV_SHIFT = m3i_pkg::FRACTION_BITS + 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  typedef logic signed [EW-1:0] elem_t;
  typedef elem_t mat_t [9];

  typedef struct {
    logic [IW-1:0] inv [9];
    logic [DW-1:0] det;
    logic          sing;
  } inverse_t;

  class inverse_scoreboard;
    inverse_t pending_q[$];
    int       errors;

    function automatic logic [63:0] div_sat(logic [63:0] num, logic [63:0] den);
      logic          neg;
      logic [63:0]   mn;
      logic [63:0]   md;
      logic [63:0]   q;
      logic [63:0]   lim;
      neg = num[63] ^ den[63];
      mn = num[63] ? -num : num;
      md = den[63] ? -den : den;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (md == 0) return 0;
      if (mn > (64'hFFFF_FFFF_FFFF_FFFF >> INV_SHIFT)) q = lim;
      else q = (mn << INV_SHIFT) / md;
      if (q > lim) q = lim;
      if (neg) q = -q;
      return q;
    endfunction

    function void note_matrix(mat_t m);
      logic [63:0] v [9];
      logic [63:0] adj [9];
      logic [63:0] det;
      inverse_t    r;
      for (int i = 0; i < 9; i++) v[i] = 64'(signed'(m[i]));
      adj[0] = v[4] * v[8] - v[7] * v[5];
      adj[1] = v[7] * v[2] - v[1] * v[8];
      adj[2] = v[1] * v[5] - v[4] * v[2];
      adj[3] = v[6] * v[5] - v[3] * v[8];
      adj[4] = v[0] * v[8] - v[6] * v[2];
      adj[5] = v[3] * v[2] - v[0] * v[5];
      adj[6] = v[3] * v[7] - v[6] * v[4];
      adj[7] = v[6] * v[1] - v[0] * v[7];
      adj[8] = v[0] * v[4] - v[3] * v[1];
      det = v[0] * adj[0] + v[1] * adj[3] + v[2] * adj[6];
      r.sing = (det == 0);
      r.det = det[DW-1:0];
      for (int i = 0; i < 9; i++) r.inv[i] = r.sing ? '0 : div_sat(adj[i], det);
      pending_q.push_back(r);
    endfunction

    function void check_result(inverse_t got);
      inverse_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result with no matrix pending");
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      for (int i = 0; i < 9; i++)
        if (got.inv[i] !== exp_r.inv[i]) begin
          $error("inv_r%0dc%0d expected %h actual %h", i / 3, i % 3, exp_r.inv[i], got.inv[i]);
          errors++;
        end
      if (got.det !== exp_r.det) begin
        $error("determinant expected %h actual %h", exp_r.det, got.det);
        errors++;
      end
      if (got.sing !== exp_r.sing) begin
        $error("singular expected %b actual %b", exp_r.sing, got.sing);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  elem_t in_m [9];
  logic out_valid;
  logic signed [IW-1:0] out_inv [9];
  logic signed [DW-1:0] out_determinant;
  logic out_singular;

  inverse_scoreboard sb = new();
  int idle_cycles = 0;

  always #5 clk = ~clk;

  matrix3_inverse_adjugate u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_r0c0(in_m[0]), .in_r0c1(in_m[1]), .in_r0c2(in_m[2]),
    .in_r1c0(in_m[3]), .in_r1c1(in_m[4]), .in_r1c2(in_m[5]),
    .in_r2c0(in_m[6]), .in_r2c1(in_m[7]), .in_r2c2(in_m[8]),
    .out_valid(out_valid),
    .out_inv_r0c0(out_inv[0]), .out_inv_r0c1(out_inv[1]), .out_inv_r0c2(out_inv[2]),
    .out_inv_r1c0(out_inv[3]), .out_inv_r1c1(out_inv[4]), .out_inv_r1c2(out_inv[5]),
    .out_inv_r2c0(out_inv[6]), .out_inv_r2c1(out_inv[7]), .out_inv_r2c2(out_inv[8]),
    .out_determinant(out_determinant), .out_singular(out_singular)
  );

  always @(posedge clk) begin
    inverse_t got;
    if (rst_n) begin
      if (out_valid) begin
        for (int i = 0; i < 9; i++) got.inv[i] = out_inv[i];
        got.det = out_determinant;
        got.sing = out_singular;
        sb.check_result(got);
      end
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic elem_t rand_elem(int mode);
    case (mode)
      0: return elem_t'($urandom);
      1: return elem_t'($urandom_range(0, 1024)) - elem_t'(512);
      2: return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
      default: return elem_t'($urandom_range(0, 6)) - elem_t'(3);
    endcase
  endfunction

  task automatic send_matrix(mat_t m, bit hold_next);
    @(negedge clk);
    in_m = m;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_matrix(m);
    if (!hold_next) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic send_gapped(mat_t m, bit last);
    int g;
    g = last ? 1 : gap_len();
    send_matrix(m, g == 0);
    repeat (g > 0 ? g - 1 : 0) @(negedge clk);
  endtask

  task automatic wait_drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    mat_t m;
    mat_t dir [$];
    int mode;
    for (int i = 0; i < 9; i++) in_m[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    m = '{default: 16'sh0000}; dir.push_back(m);
    m = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100}; dir.push_back(m);
    m = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF}; dir.push_back(m);
    m = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000}; dir.push_back(m);
    m = '{16'sh0001, 0, 0, 0, 16'sh0001, 0, 0, 0, 16'sh0001}; dir.push_back(m);
    m = '{16'shFFFF, 0, 0, 0, 16'sh0001, 0, 0, 0, 16'sh0001}; dir.push_back(m);
    m = '{default: 16'sh7FFF}; dir.push_back(m);
    m = '{default: 16'sh8000}; dir.push_back(m);
    m = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
          16'sh8000, 16'sh7FFF, 16'sh7FFF}; dir.push_back(m);
    m = '{16'sh7FFF, 16'sh8000, 0, 16'sh8000, 16'sh7FFF, 0, 0, 0, 16'sh8000};
    dir.push_back(m);
    m = '{1, 2, 3, 4, 5, 6, 7, 8, 9}; dir.push_back(m);
    m = '{0, 16'sh0100, 0, 0, 0, 16'sh0100, 16'sh0100, 0, 0}; dir.push_back(m);
    m = '{16'sh0200, 16'sh0100, 0, 16'sh0100, 16'sh0300, 16'sh0100,
          0, 16'sh0100, 16'sh0400}; dir.push_back(m);
    m = '{16'shFF00, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100}; dir.push_back(m);
    foreach (dir[i]) send_matrix(dir[i], i != dir.size() - 1);
    wait_drain();

    for (int n = 0; n < 1250; n++) begin
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++)
        m[i] = rand_elem(mode < 4 ? 0 : mode < 7 ? 1 : mode < 8 ? 2 : 3);
      if ($urandom_range(0, 19) == 0)
        for (int i = 0; i < 3; i++) m[6 + i] = m[3 + i];
      if (n == 600) wait_drain();
      send_gapped(m, n == 1249 || n == 599);
    end

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl
rtl/m3i_pkg.sv
rtl/m3i_cofactor.sv
rtl/m3i_div_lane.sv
rtl/matrix3_inverse_adjugate.sv
tb/matrix3_inverse_adjugate_tb.sv
